[rtl/core/lbat_pkg.sv]
package lbat_pkg;

	localparam int NUM_LEDS   = 5;
	localparam int TIME_WIDTH = 16;

	localparam int CMD_W     = 2;
	localparam int INDEX_W   = 3;
	localparam int DUR_W     = 16;
	localparam int ELAPSED_W = 16;
	localparam int MASK_W    = 5;
	localparam int PIN_COUNT = 5;
	localparam int PORT_A_W  = 2;
	localparam int PORT_B_W  = 3;

	localparam int CMP_W = (TIME_WIDTH > ELAPSED_W) ? TIME_WIDTH : ELAPSED_W;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 16;

	localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(3);

	typedef enum logic [CMD_W-1:0] {
		CMD_ON       = 2'd0,
		CMD_OFF      = 2'd1,
		CMD_ON_TIMED = 2'd2,
		CMD_TICK     = 2'd3
	} cmd_t;

	typedef struct packed {
		logic sel;
		cmd_t cmd;
	} led_ctl_t;

endpackage

[rtl/core/lbat_timer.sv]
module lbat_timer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lbat_pkg::led_ctl_t                   ctl,
	input  logic [lbat_pkg::DUR_W-1:0]           duration,
	input  logic [lbat_pkg::ELAPSED_W-1:0]       elapsed,
	output logic                                 on_next,
	output logic                                 on_q
);
	import lbat_pkg::*;

	logic [TIME_WIDTH-1:0] time_q;
	logic [TIME_WIDTH-1:0] time_next;
	logic                  expired;

	assign expired = CMP_W'(elapsed) >= CMP_W'(time_q);

	always_comb begin
		on_next   = on_q;
		time_next = time_q;
		if (ctl.sel) begin
			unique case (ctl.cmd)
				CMD_ON: begin
					on_next = 1'b1;
				end
				CMD_OFF: begin
					on_next = 1'b0;
				end
				CMD_ON_TIMED: begin
					on_next   = 1'b1;
					time_next = TIME_WIDTH'(duration);
				end
				CMD_TICK: begin
					if (time_q != '0) begin
						if (expired) begin
							time_next = '0;
							on_next   = 1'b0;
						end else begin
							time_next = time_q - TIME_WIDTH'(elapsed);
						end
					end
				end
				default: begin
					on_next = on_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q   <= 1'b0;
			time_q <= '0;
		end else begin
			on_q   <= on_next;
			time_q <= time_next;
		end
	end

endmodule

[rtl/core/led_bank_with_auto_off_timers_top.sv]
// Channel  Direction  Handshake            Payload
// s        in         s_tvalid/s_tready    s_tuser: command; s_tdata: index, duration, elapsed
// m        out        m_tvalid/m_tready    m_tdata: led_states, port_a_pins, port_b_pins
// cfg      in         cfg_valid/cfg_ready  cfg_data: active_high_mask
//
// One word is taken per cycle while s_tready is high; its result shows on m in the cycle after acceptance.
// The LED timers and the result register update in the same edge that accepts the word.
// An input word is taken whenever the result register is empty or being drained.
// Reset clears all LEDs and timers and sets the polarity mask to LEDs 0 and 1 active high.
module led_bank_with_auto_off_timers_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// Bits from low: led_index[2:0], duration_ms[18:3], elapsed_ms[34:19], zero fill.
	input  logic [lbat_pkg::S_DATA_W-1:0]     s_tdata,
	// Bits from low: command[1:0].
	input  logic [lbat_pkg::CMD_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// Bits from low: led_states[4:0], port_a_pins[6:5], port_b_pins[9:7], zero fill.
	output logic [lbat_pkg::M_DATA_W-1:0]     m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lbat_pkg::MASK_W-1:0]       cfg_data
);
	import lbat_pkg::*;

	logic                       s_accept;
	cmd_t                       cmd;
	logic [INDEX_W-1:0]         led_index;
	logic [DUR_W-1:0]           duration_ms;
	logic [ELAPSED_W-1:0]       elapsed_ms;
	logic [MASK_W-1:0]          mask_q;
	logic [NUM_LEDS-1:0]        on_next;
	logic [NUM_LEDS-1:0]        on_q;
	logic [PIN_COUNT+NUM_LEDS-1:0] on_pad;
	logic [PIN_COUNT+NUM_LEDS-1:0] on_q_pad;
	logic [PIN_COUNT-1:0]       on_ext;
	logic [PIN_COUNT-1:0]       pins;
	logic [M_DATA_W-1:0]        result;
	logic [M_DATA_W-1:0]        result_q;
	logic                       valid_q;

	assign s_tready  = !valid_q || m_tready;
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign cmd         = cmd_t'(s_tuser);
	assign led_index   = s_tdata[INDEX_W-1:0];
	assign duration_ms = s_tdata[INDEX_W+DUR_W-1:INDEX_W];
	assign elapsed_ms  = s_tdata[INDEX_W+DUR_W+ELAPSED_W-1:INDEX_W+DUR_W];

	for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
		led_ctl_t ctl;
		always_comb begin
			ctl.cmd = cmd;
			ctl.sel = s_accept && ((cmd == CMD_TICK) || (int'(led_index) == i));
		end
		lbat_timer u_timer (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.duration (duration_ms),
			.elapsed  (elapsed_ms),
			.on_next  (on_next[i]),
			.on_q     (on_q[i])
		);
	end

	assign on_pad   = {{PIN_COUNT{1'b0}}, on_next};
	assign on_q_pad = {{PIN_COUNT{1'b0}}, on_q};
	assign on_ext   = on_pad[PIN_COUNT-1:0];
	assign pins     = on_ext ~^ mask_q;

	assign result = M_DATA_W'({pins[2], pins[3], pins[4], pins[1], pins[0], on_ext});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= MASK_RESET;
			valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mask_q <= cfg_data;
			end
			if (s_accept) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			result_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = result_q;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> m_tvalid)
		else $error("accepted word produced no result");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[PIN_COUNT-1:0] == on_q_pad[PIN_COUNT-1:0]))
		else $error("result LED states differ from LED registers");

endmodule

[tb/tb_led_bank_with_auto_off_timers_top.sv]
`timescale 1ns / 100ps

module tb_led_bank_with_auto_off_timers_top;
	import lbat_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int MAX_SHOWN  = 10;

	typedef struct packed {
		logic [PORT_B_W-1:0] port_b;
		logic [PORT_A_W-1:0] port_a;
		logic [NUM_LEDS-1:0] states;
	} led_view_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0]    s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [MASK_W-1:0]   cfg_data = '0;

	// Shadow copy of the bank state.
	logic [NUM_LEDS-1:0]   lamp_on;
	logic [TIME_WIDTH-1:0] lamp_timer [NUM_LEDS];
	logic [MASK_W-1:0]     polarity_mask;

	led_view_t pending_views [$];
	int        fail_count = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;

	led_bank_with_auto_off_timers_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic led_view_t advance_leds(cmd_t cmd, logic [INDEX_W-1:0] idx,
			logic [DUR_W-1:0] dur, logic [ELAPSED_W-1:0] elapsed);
		led_view_t           view;
		logic [NUM_LEDS-1:0] pin;
		if (cmd == CMD_TICK) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				if (lamp_timer[i] != '0) begin
					if (elapsed >= lamp_timer[i]) begin
						lamp_timer[i] = '0;
						lamp_on[i] = 1'b0;
					end else begin
						lamp_timer[i] = lamp_timer[i] - elapsed;
					end
				end
			end
		end else if (idx < NUM_LEDS) begin
			if (cmd == CMD_OFF) begin
				lamp_on[idx] = 1'b0;
			end else begin
				lamp_on[idx] = 1'b1;
				if (cmd == CMD_ON_TIMED)
					lamp_timer[idx] = TIME_WIDTH'(dur);
			end
		end
		for (int i = 0; i < NUM_LEDS; i++)
			pin[i] = polarity_mask[i] ? lamp_on[i] : ~lamp_on[i];
		view.states = lamp_on;
		view.port_a = {pin[1], pin[0]};
		view.port_b = {pin[2], pin[3], pin[4]};
		return view;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_SHOWN)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk or negedge arst_n) begin
		led_view_t got;
		led_view_t want;
		if (!arst_n) begin
			lamp_on = '0;
			for (int i = 0; i < NUM_LEDS; i++)
				lamp_timer[i] = '0;
			polarity_mask = MASK_RESET;
		end else begin
			if (m_tvalid && m_tready) begin
				got = led_view_t'(m_tdata[9:0]);
				if (pending_views.size() == 0) begin
					note_failure($sformatf("result word %h with no expectation", m_tdata));
				end else begin
					want = pending_views.pop_front();
					if (got.states !== want.states)
						note_failure($sformatf("led_states exp %b got %b",
							want.states, got.states));
					if (got.port_a !== want.port_a)
						note_failure($sformatf("port_a_pins exp %b got %b",
							want.port_a, got.port_a));
					if (got.port_b !== want.port_b)
						note_failure($sformatf("port_b_pins exp %b got %b",
							want.port_b, got.port_b));
					if (m_tdata[M_DATA_W-1:10] !== '0)
						note_failure($sformatf("fill bits exp 0 got %h",
							m_tdata[M_DATA_W-1:10]));
				end
			end
			if (s_tvalid && s_tready)
				pending_views.push_back(advance_leds(cmd_t'(s_tuser), s_tdata[2:0],
					s_tdata[18:3], s_tdata[34:19]));
			if (cfg_valid && cfg_ready)
				polarity_mask = cfg_data;
		end
	end

	task automatic send_word(input cmd_t cmd, input logic [INDEX_W-1:0] idx,
			input logic [DUR_W-1:0] dur, input logic [ELAPSED_W-1:0] elapsed);
		int gap;
		gap = 0;
		if (send_idle_pct > 0)
			while ($urandom_range(99) < send_idle_pct)
				gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {5'b0, elapsed, dur, idx};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_mask(input logic [MASK_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_word();
		cmd_t               cmd;
		logic [INDEX_W-1:0] idx;
		logic [DUR_W-1:0]   dur;
		logic [ELAPSED_W-1:0] elapsed;
		int                 pick;
		pick = $urandom_range(99);
		cmd = (pick < 25) ? CMD_ON : (pick < 45) ? CMD_OFF :
			(pick < 75) ? CMD_ON_TIMED : CMD_TICK;
		idx = ($urandom_range(9) == 0) ? INDEX_W'($urandom_range(7)) :
			INDEX_W'($urandom_range(NUM_LEDS - 1));
		pick = $urandom_range(9);
		dur = (pick == 0) ? '0 : (pick < 3) ? DUR_W'($urandom) :
			DUR_W'($urandom_range(1, 300));
		pick = $urandom_range(9);
		elapsed = (pick == 0) ? '0 : (pick == 1) ? ELAPSED_W'($urandom) :
			ELAPSED_W'($urandom_range(1, 120));
		if (cmd == CMD_TICK && $urandom_range(1)) begin
			idx = INDEX_W'($urandom);
			dur = DUR_W'($urandom);
		end
		send_word(cmd, idx, dur, elapsed);
	endtask

	task automatic test_directed_commands();
		for (int i = 0; i < NUM_LEDS; i++)
			send_word(CMD_ON, INDEX_W'(i), '0, '0);
		send_word(CMD_OFF, 3'd2, '1, '1);
		send_word(CMD_ON, 3'd5, '0, '0);
		send_word(CMD_OFF, 3'd6, '0, '0);
		send_word(CMD_ON_TIMED, 3'd7, 16'd10, '0);
		send_word(CMD_ON_TIMED, 3'd1, 16'hFFFF, '0);
		send_word(CMD_ON_TIMED, 3'd3, 16'd1, '0);
		send_word(CMD_ON_TIMED, 3'd4, 16'd0, '0);
		send_word(CMD_ON_TIMED, 3'd0, 16'd100, '0);
		send_word(CMD_TICK, 3'd7, 16'hFFFF, 16'd0);
		send_word(CMD_OFF, 3'd0, '0, '0);
		send_word(CMD_ON, 3'd0, '0, '0);
		send_word(CMD_TICK, 3'd0, '0, 16'd1);
		send_word(CMD_TICK, 3'd0, '0, 16'd99);
		send_word(CMD_TICK, 3'd0, '0, 16'hFFFF);
		send_word(CMD_ON_TIMED, 3'd2, 16'd50, '0);
		send_word(CMD_ON_TIMED, 3'd2, 16'd0, '0);
		send_word(CMD_TICK, 3'd5, 16'h1234, 16'hFFFF);
		wait_drained();
	endtask

	task automatic test_polarity_settings();
		logic [MASK_W-1:0] masks [4];
		masks = '{5'b00000, 5'b11111, 5'b10101, 5'b01010};
		foreach (masks[k]) begin
			write_mask(masks[k]);
			send_word(CMD_ON, INDEX_W'($urandom_range(NUM_LEDS - 1)), '0, '0);
			send_word(CMD_OFF, INDEX_W'($urandom_range(NUM_LEDS - 1)), '0, '0);
			send_word(CMD_TICK, '0, '0, 16'd0);
		end
		wait_drained();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int count);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 160 == 0)
				write_mask(MASK_W'($urandom));
			send_random_word();
		end
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_commands();
		test_polarity_settings();
		test_random_traffic(0, 0, 480);
		write_mask('1);
		test_random_traffic(81, 0, 470);
		write_mask('0);
		test_random_traffic(0, 81, 470);
		test_random_traffic(33, 33, 480);
		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending_views.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
